[rtl/reh_pkg.sv]
// ----------------------------------------------------------------------------
// reh_pkg
// Shared widths, constants, types and the arctangent table of the rotated
// ellipse hit test.
// ----------------------------------------------------------------------------
`default_nettype none

package reh_pkg;

  localparam int ROTATE_ITERATIONS = 16;
  localparam int ATAN_ENTRIES      = 24;
  localparam int NUM_CELLS = (ROTATE_ITERATIONS > ATAN_ENTRIES) ? ATAN_ENTRIES
                                                                 : ROTATE_ITERATIONS;

  localparam int CW  = 24;  // coordinate width
  localparam int RW  = 23;  // radius width
  localparam int AW  = 16;  // angle width
  localparam int MW  = 16;  // margin width
  localparam int XW  = 36;  // rotator x/y width
  localparam int ZW  = 27;  // rotator angle accumulator width
  localparam int DW  = 28;  // offset width after gain correction
  localparam int UW  = 28;  // corner magnitude width
  localparam int PW  = 51;  // magnitude times radius
  localparam int SW  = 102; // squared term width
  localparam int GW  = 25;  // inverse gain constant width
  localparam int SHW = 5;   // shift amount width

  localparam logic signed [AW:0]  HALF_TURN    = 17'sd11520;
  localparam logic signed [AW:0]  FULL_TURN    = 17'sd23040;
  localparam logic signed [AW:0]  QUARTER_TURN = 17'sd5760;
  localparam logic signed [GW-1:0] INV_GAIN    = 25'sd10188014;

  localparam logic [2:0] REG_CENTER_X = 3'd0;
  localparam logic [2:0] REG_CENTER_Y = 3'd1;
  localparam logic [2:0] REG_RADIUS_X = 3'd2;
  localparam logic [2:0] REG_RADIUS_Y = 3'd3;
  localparam logic [2:0] REG_ROTATION = 3'd4;
  localparam logic [2:0] REG_PIVOT_X  = 3'd5;
  localparam logic [2:0] REG_PIVOT_Y  = 3'd6;

  localparam logic [1:0] CLS_OUTSIDE = 2'd0;
  localparam logic [1:0] CLS_INSIDE  = 2'd1;
  localparam logic [1:0] CLS_EDGE    = 2'd2;

  typedef struct packed {
    logic                 vld;
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic [MW-1:0]        margin;
  } cordic_t;

  typedef struct packed {
    logic       vld;
    logic [1:0] cls;
  } result_t;

  function automatic logic [ZW-1:0] atan_step(input logic [SHW-1:0] idx);
    logic [ZW-1:0] v;
    case (idx)
      5'd0:  v = 27'd11796480;
      5'd1:  v = 27'd6963869;
      5'd2:  v = 27'd3679517;
      5'd3:  v = 27'd1867780;
      5'd4:  v = 27'd937515;
      5'd5:  v = 27'd469214;
      5'd6:  v = 27'd234664;
      5'd7:  v = 27'd117339;
      5'd8:  v = 27'd58671;
      5'd9:  v = 27'd29335;
      5'd10: v = 27'd14668;
      5'd11: v = 27'd7334;
      5'd12: v = 27'd3667;
      5'd13: v = 27'd1833;
      5'd14: v = 27'd917;
      5'd15: v = 27'd458;
      5'd16: v = 27'd229;
      5'd17: v = 27'd115;
      5'd18: v = 27'd57;
      5'd19: v = 27'd29;
      5'd20: v = 27'd14;
      5'd21: v = 27'd7;
      5'd22: v = 27'd4;
      5'd23: v = 27'd2;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

[rtl/rotated_ellipse_hit_test.sv]
// ----------------------------------------------------------------------------
// rotated_ellipse_hit_test
// Classifies query points against a rotated ellipse as outside, inside or on
// the outline.
// ----------------------------------------------------------------------------
// The block takes one query point per cycle while s_tready is high and returns
// one hit class per point, in order. The path from the accepting edge to the
// result on the master side runs through one registered rotator cell per CORDIC
// iteration, six stages of gain correction and wide cross products, and the
// output register; the input register is loaded at the accepting edge itself.
// An output skid register lets the pipeline take new transactions while a result
// waits on the master side; once the skid register is full, s_tready drops.
`default_nettype none

module rotated_ellipse_hit_test
  import reh_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [63:0] s_tdata,   // query_x[23:0], query_y[47:24], margin[63:48]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [7:0]       m_tdata    // hit_class[1:0], zero fill above
);

  logic signed [CW-1:0] center_x;
  logic signed [CW-1:0] center_y;
  logic [RW-1:0]        semi_x;
  logic [RW-1:0]        semi_y;
  logic signed [AW-1:0] rotation_angle;
  logic signed [CW-1:0] pivot_x;
  logic signed [CW-1:0] pivot_y;

  logic [2:0]           reg_idx;
  logic                 en;
  cordic_t              chain [NUM_CELLS+1];
  cordic_t              stage0_next;
  result_t              res;
  logic                 out_vld;
  logic [1:0]           out_cls;
  logic                 skid_vld;
  logic [1:0]           skid_cls;

  logic signed [CW+1:0] vx;
  logic signed [CW+1:0] vy;
  logic signed [AW:0]   t0;
  logic signed [AW:0]   t1;
  logic signed [AW:0]   t2;
  logic                 flip;
  logic signed [XW-1:0] x0;
  logic signed [XW-1:0] y0;

  assign reg_idx = paddr[4:2];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x       <= '0;
      center_y       <= '0;
      semi_x         <= '0;
      semi_y         <= '0;
      rotation_angle <= '0;
      pivot_x        <= '0;
      pivot_y        <= '0;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        REG_CENTER_X: center_x       <= pwdata[CW-1:0];
        REG_CENTER_Y: center_y       <= pwdata[CW-1:0];
        REG_RADIUS_X: semi_x         <= pwdata[RW-1:0];
        REG_RADIUS_Y: semi_y         <= pwdata[RW-1:0];
        REG_ROTATION: rotation_angle <= pwdata[AW-1:0];
        REG_PIVOT_X:  pivot_x        <= pwdata[CW-1:0];
        REG_PIVOT_Y:  pivot_y        <= pwdata[CW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_CENTER_X: prdata = {{(32-CW){1'b0}}, center_x};
      REG_CENTER_Y: prdata = {{(32-CW){1'b0}}, center_y};
      REG_RADIUS_X: prdata = {{(32-RW){1'b0}}, semi_x};
      REG_RADIUS_Y: prdata = {{(32-RW){1'b0}}, semi_y};
      REG_ROTATION: prdata = {{(32-AW){1'b0}}, rotation_angle};
      REG_PIVOT_X:  prdata = {{(32-CW){1'b0}}, pivot_x};
      REG_PIVOT_Y:  prdata = {{(32-CW){1'b0}}, pivot_y};
      default:      prdata = '0;
    endcase
  end

  always_comb begin
    vx = (CW+2)'($signed(s_tdata[23:0])) - (CW+2)'(center_x) - (CW+2)'(pivot_x);
    vy = (CW+2)'($signed(s_tdata[47:24])) - (CW+2)'(center_y) - (CW+2)'(pivot_y);
    t0 = -(AW+1)'(rotation_angle);
    if (t0 > HALF_TURN) begin
      t1 = t0 - FULL_TURN;
    end else if (t0 <= -HALF_TURN) begin
      t1 = t0 + FULL_TURN;
    end else begin
      t1 = t0;
    end
    flip = 1'b0;
    if (t1 > QUARTER_TURN) begin
      t2   = t1 - HALF_TURN;
      flip = 1'b1;
    end else if (t1 < -QUARTER_TURN) begin
      t2   = t1 + HALF_TURN;
      flip = 1'b1;
    end else begin
      t2 = t1;
    end
    x0 = XW'(vx) <<< 8;
    y0 = XW'(vy) <<< 8;
    stage0_next.vld    = s_tvalid;
    stage0_next.x      = flip ? -x0 : x0;
    stage0_next.y      = flip ? -y0 : y0;
    stage0_next.z      = ZW'(t2) <<< 12;
    stage0_next.margin = s_tdata[63:48];
  end

  assign en       = !skid_vld;
  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      chain[0].vld <= 1'b0;
    end else if (en) begin
      chain[0] <= stage0_next;
    end
  end

  for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
    reh_cordic_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .en    (en),
      .din   (chain[g]),
      .shift (SHW'(g)),
      .dout  (chain[g+1])
    );
  end

  reh_ellipse u_ellipse (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .din     (chain[NUM_CELLS]),
    .semi_x  (semi_x),
    .semi_y  (semi_y),
    .pivot_x (pivot_x),
    .pivot_y (pivot_y),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld  <= 1'b0;
      skid_vld <= 1'b0;
    end else if (!out_vld || m_tready) begin
      if (skid_vld) begin
        out_vld  <= 1'b1;
        out_cls  <= skid_cls;
        skid_vld <= 1'b0;
      end else begin
        out_vld <= res.vld;
        out_cls <= res.cls;
      end
    end else if (res.vld && en) begin
      skid_vld <= 1'b1;
      skid_cls <= res.cls;
    end
  end

  assign m_tvalid = out_vld;
  assign m_tdata  = {6'b0, out_cls};

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_vld |-> out_vld) else $error("skid register full while output empty");

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> chain[0].vld) else $error("accepted point lost");

  a_held_result: assert property (@(posedge clk) disable iff (rst)
    (out_vld && !m_tready) |=> (out_vld && $stable(out_cls)))
    else $error("held result changed");

  a_class_code: assert property (@(posedge clk) disable iff (rst)
    out_vld |-> (out_cls == CLS_OUTSIDE || out_cls == CLS_INSIDE || out_cls == CLS_EDGE))
    else $error("illegal hit class");

endmodule

`default_nettype wire

[rtl/reh_cordic_cell.sv]
// ----------------------------------------------------------------------------
// reh_cordic_cell
// One registered micro-rotation of the rotator chain.
// ----------------------------------------------------------------------------
`default_nettype none

module reh_cordic_cell
  import reh_pkg::*;
(
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           en,
  input  wire cordic_t        din,
  input  wire logic [SHW-1:0] shift,
  output cordic_t             dout
);

  logic signed [XW-1:0] xs;
  logic signed [XW-1:0] ys;
  logic signed [ZW-1:0] step;
  cordic_t              dout_next;

  always_comb begin
    xs   = din.x >>> shift;
    ys   = din.y >>> shift;
    step = $signed(atan_step(shift));
    dout_next = din;
    if (!din.z[ZW-1]) begin
      dout_next.x = din.x - ys;
      dout_next.y = din.y + xs;
      dout_next.z = din.z - step;
    end else begin
      dout_next.x = din.x + ys;
      dout_next.y = din.y - xs;
      dout_next.z = din.z + step;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.vld <= 1'b0;
    end else if (en) begin
      dout <= dout_next;
    end
  end

endmodule

`default_nettype wire

[rtl/reh_ellipse.sv]
// ----------------------------------------------------------------------------
// reh_ellipse
// Gain correction, corner offsets and the cross-multiplied ellipse check.
// ----------------------------------------------------------------------------
`default_nettype none

module reh_ellipse
  import reh_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 en,
  input  wire cordic_t              din,
  input  wire logic [RW-1:0]        semi_x,
  input  wire logic [RW-1:0]        semi_y,
  input  wire logic signed [CW-1:0] pivot_x,
  input  wire logic signed [CW-1:0] pivot_y,
  output result_t                   res
);

  localparam int PRW = XW + GW;

  // Gain product stage.
  logic                  g_vld;
  logic signed [PRW-1:0] g_px;
  logic signed [PRW-1:0] g_py;
  logic [MW-1:0]         g_m;
  // Offset stage.
  logic                  d_vld;
  logic signed [DW-1:0]  d_x;
  logic signed [DW-1:0]  d_y;
  logic [MW-1:0]         d_m;
  // Corner magnitude stage.
  logic                  a_vld;
  logic [UW-1:0]         a_u [4];
  logic                  a_box;
  logic                  a_nz;
  // Cross product stage.
  logic                  p_vld;
  logic [PW-1:0]         p_v [5];
  logic                  p_box;
  logic                  p_nz;
  // Partial square stage.
  logic                  q_vld;
  logic [51:0]           q_hh [5];
  logic [50:0]           q_hl [5];
  logic [49:0]           q_ll [5];
  logic                  q_box;
  logic                  q_nz;
  // Square stage.
  logic                  s_vld;
  logic [SW-1:0]         s_sq [5];
  logic                  s_box;
  logic                  s_nz;

  logic signed [PRW:0]   rnd_x;
  logic signed [PRW:0]   rnd_y;
  logic signed [DW-1:0]  dx_next;
  logic signed [DW-1:0]  dy_next;
  logic signed [DW:0]    dxm;
  logic signed [DW:0]    dxp;
  logic signed [DW:0]    dym;
  logic signed [DW:0]    dyp;
  logic signed [DW:0]    rxm;
  logic signed [DW:0]    rxp;
  logic signed [DW:0]    rym;
  logic signed [DW:0]    ryp;
  logic signed [DW:0]    dx_w;
  logic signed [DW:0]    dy_w;
  logic signed [DW:0]    corner [4];
  logic [UW-1:0]         u_next [4];
  logic                  box_next;
  logic [SW:0]           sum [4];
  logic [SW:0]           lim;
  logic                  le;
  logic                  ge;
  logic [1:0]            cls_next;

  always_comb begin
    rnd_x   = {g_px[PRW-1], g_px} + ((PRW+1)'(1) <<< 31);
    rnd_y   = {g_py[PRW-1], g_py} + ((PRW+1)'(1) <<< 31);
    dx_next = rnd_x[32+DW-1:32] + DW'(pivot_x);
    dy_next = rnd_y[32+DW-1:32] + DW'(pivot_y);
  end

  always_comb begin
    dx_w = (DW+1)'(d_x);
    dy_w = (DW+1)'(d_y);
    dxm  = dx_w - $signed({{(DW+1-MW){1'b0}}, d_m});
    dxp  = dx_w + $signed({{(DW+1-MW){1'b0}}, d_m});
    dym  = dy_w - $signed({{(DW+1-MW){1'b0}}, d_m});
    dyp  = dy_w + $signed({{(DW+1-MW){1'b0}}, d_m});
    rxm  = $signed({{(DW+1-RW){1'b0}}, semi_x}) - $signed({{(DW+1-MW){1'b0}}, d_m});
    rxp  = $signed({{(DW+1-RW){1'b0}}, semi_x}) + $signed({{(DW+1-MW){1'b0}}, d_m});
    rym  = $signed({{(DW+1-RW){1'b0}}, semi_y}) - $signed({{(DW+1-MW){1'b0}}, d_m});
    ryp  = $signed({{(DW+1-RW){1'b0}}, semi_y}) + $signed({{(DW+1-MW){1'b0}}, d_m});
    corner[0] = dxm;
    corner[1] = dxp;
    corner[2] = dym;
    corner[3] = dyp;
    for (int k = 0; k < 4; k++) begin
      u_next[k] = corner[k][DW] ? UW'(-corner[k]) : UW'(corner[k]);
    end
    box_next = (rxm <= dx_w) && (dx_w <= rxp) && (rym <= dy_w) && (dy_w <= ryp);
  end

  always_comb begin
    lim = (SW+1)'(s_sq[4]);
    le  = 1'b0;
    ge  = 1'b0;
    for (int a = 0; a < 2; a++) begin
      for (int b = 0; b < 2; b++) begin
        sum[2*a+b] = (SW+1)'(s_sq[a]) + (SW+1)'(s_sq[2+b]);
      end
    end
    for (int k = 0; k < 4; k++) begin
      if (sum[k] <= lim) le = 1'b1;
      if (sum[k] >= lim) ge = 1'b1;
    end
    if (s_nz) begin
      cls_next = (le && ge) ? CLS_EDGE : (le ? CLS_INSIDE : CLS_OUTSIDE);
    end else begin
      cls_next = s_box ? CLS_EDGE : CLS_OUTSIDE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      g_vld   <= 1'b0;
      d_vld   <= 1'b0;
      a_vld   <= 1'b0;
      p_vld   <= 1'b0;
      q_vld   <= 1'b0;
      s_vld   <= 1'b0;
    end else if (en) begin
      g_vld <= din.vld;
      g_px  <= din.x * INV_GAIN;
      g_py  <= din.y * INV_GAIN;
      g_m   <= din.margin;

      d_vld <= g_vld;
      d_x   <= dx_next;
      d_y   <= dy_next;
      d_m   <= g_m;

      a_vld <= d_vld;
      a_u   <= u_next;
      a_box <= box_next;
      a_nz  <= (semi_x != '0) && (semi_y != '0);

      p_vld  <= a_vld;
      p_v[0] <= PW'(a_u[0] * semi_y);
      p_v[1] <= PW'(a_u[1] * semi_y);
      p_v[2] <= PW'(a_u[2] * semi_x);
      p_v[3] <= PW'(a_u[3] * semi_x);
      p_v[4] <= PW'(semi_x * semi_y);
      p_box  <= a_box;
      p_nz   <= a_nz;

      q_vld <= p_vld;
      for (int k = 0; k < 5; k++) begin
        q_hh[k] <= p_v[k][50:25] * p_v[k][50:25];
        q_hl[k] <= p_v[k][50:25] * p_v[k][24:0];
        q_ll[k] <= p_v[k][24:0] * p_v[k][24:0];
      end
      q_box <= p_box;
      q_nz  <= p_nz;

      s_vld <= q_vld;
      for (int k = 0; k < 5; k++) begin
        s_sq[k] <= (SW'(q_hh[k]) << 50) + (SW'(q_hl[k]) << 26) + SW'(q_ll[k]);
      end
      s_box <= q_box;
      s_nz  <= q_nz;
    end
  end

  assign res.vld = s_vld;
  assign res.cls = cls_next;

endmodule

`default_nettype wire
